FILE: sv/chb_pkg.sv
// Shared types and constants for the convex hull builder.
package chb_pkg;

    // Number of clock cycles from a turn request to its result.
    localparam int unsigned TURN_LATENCY = 3;

    // Result of one orientation test, passed from the turn unit to the controller.
    typedef struct packed {
        logic valid;
        logic non_left;
    } chb_turn_res_t;

endpackage

FILE: sv/chb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module chb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/chb_turn.sv
// Pipelined orientation test: is the turn a -> b -> c clockwise or straight.
module chb_turn #(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] c_x,
    input  logic signed [COORD_BITS-1:0] c_y,
    output chb_pkg::chb_turn_res_t       res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [PW-1:0] m1_reg, m2_reg;
    logic                 non_left_reg;
    logic [chb_pkg::TURN_LATENCY-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        ux_reg       <= DW'(b_x) - DW'(a_x);
        uy_reg       <= DW'(b_y) - DW'(a_y);
        vx_reg       <= DW'(c_x) - DW'(a_x);
        vy_reg       <= DW'(c_y) - DW'(a_y);
        m1_reg       <= PW'(ux_reg) * PW'(vy_reg);
        m2_reg       <= PW'(uy_reg) * PW'(vx_reg);
        // The cross product is zero or negative exactly when m1 <= m2.
        non_left_reg <= (m1_reg <= m2_reg);
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[chb_pkg::TURN_LATENCY-2:0], start};
        end
    end

    assign res.valid    = vld_reg[chb_pkg::TURN_LATENCY-1];
    assign res.non_left = non_left_reg;

endmodule

FILE: sv/convex_hull_builder.sv
// Top level of the convex hull builder: loading, sort, hull build and output.
//
// The block takes a set of points on the s_ channel, one request per cycle,
// with s_last_point marking the final point of the set. Up to MAX_POINTS
// points are kept in the point RAM; further points are dropped and every
// vertex of that set is reported with m_overflowed high.
// After the last point the block sorts the points in place by x, then y,
// with an insertion sort on the point RAM: each point is read as the key,
// and larger elements are shifted up one by one until the key is placed.
// The hull is then built on the stack RAM, with the two top entries
// cached in registers: each point is fetched, then a check either pushes
// it or starts a turn test and waits for its result from the orientation
// pipeline, and after a pop the new second entry is refetched if any.
// Vertices are read from the stack RAM one at a time into the result
// register, counterclockwise from the smallest point, the final one with
// m_last_vertex. A set of one point gives a single request with m_no_hull.
// While a set is being processed s_ready is low. The result register holds
// a request until the receiver takes it; a stall simply holds the emit
// sequence. Loading of the next set starts as soon as the final vertex sits
// in the result register. A synchronous reset (aresetn low) empties the
// point set and the stack; RAM contents need no clearing.
module convex_hull_builder #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic                         s_last_point,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_hull_x,
    output logic signed [COORD_BITS-1:0] m_hull_y,
    output logic                         m_last_vertex,
    output logic                         m_no_hull,
    output logic                         m_overflowed
);

    localparam int PW      = 2 * COORD_BITS;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int SDEPTH  = MAX_POINTS + 1;
    localparam int SADDR_W = $clog2(SDEPTH);
    localparam int TOP_W   = $clog2(SDEPTH + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_KEY,
        ST_SORT_SHIFT,
        ST_SORT_PLACE,
        ST_H_RDP,
        ST_H_GETP,
        ST_H_CHECK,
        ST_H_TURN,
        ST_H_FETCH,
        ST_E_RD,
        ST_E_OUT,
        ST_E_NOHULL
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg, i_reg, j_reg, idx_reg;
    logic [TOP_W-1:0]    top_reg, floor_reg, k_reg;
    logic                ovf_reg, upper_reg;
    logic [PW-1:0]       key_reg, p_reg, a_reg, b_reg;
    logic                m_valid_reg, m_last_reg, m_no_hull_reg, m_ovf_reg;
    logic [COORD_BITS-1:0] m_x_reg, m_y_reg;

    logic               pt_we, st_we;
    logic [IDX_W-1:0]   pt_waddr, pt_raddr;
    logic [SADDR_W-1:0] st_waddr, st_raddr;
    logic [PW-1:0]      pt_wdata, pt_rdata, st_rdata;
    logic               turn_start, key_less, can_pop, out_free, out_load;
    logic [TOP_W-1:0]   push_top;
    logic [CNT_W-1:0]   jm1, jm2, im1;
    logic [TOP_W-1:0]   topm3;

    chb_pkg::chb_turn_res_t turn_res;

    function automatic logic pt_less(input logic [PW-1:0] p, input logic [PW-1:0] q);
        logic signed [COORD_BITS-1:0] px, py, qx, qy;
        px = p[PW-1:COORD_BITS];
        py = p[COORD_BITS-1:0];
        qx = q[PW-1:COORD_BITS];
        qy = q[COORD_BITS-1:0];
        if (px != qx) begin
            return px < qx;
        end
        return py < qy;
    endfunction

    assign key_less = pt_less(key_reg, pt_rdata);
    assign can_pop  = (top_reg >= TOP_W'(2)) && (top_reg > floor_reg);
    assign push_top = (top_reg < TOP_W'(SDEPTH)) ? top_reg + TOP_W'(1) : top_reg;
    assign out_free = !m_valid_reg || m_ready;
    // A new result enters the output register in this cycle.
    assign out_load = out_free && (state_reg == ST_E_OUT || state_reg == ST_E_NOHULL);
    assign jm1      = j_reg - CNT_W'(1);
    assign jm2      = j_reg - CNT_W'(2);
    assign im1      = i_reg - CNT_W'(1);
    assign topm3    = top_reg - TOP_W'(3);
    assign s_ready  = (state_reg == ST_LOAD);

    // RAM port steering.
    always_comb begin
        pt_we      = 1'b0;
        pt_waddr   = count_reg[IDX_W-1:0];
        pt_wdata   = {s_point_x, s_point_y};
        pt_raddr   = idx_reg[IDX_W-1:0];
        st_we      = 1'b0;
        st_waddr   = top_reg[SADDR_W-1:0];
        st_raddr   = k_reg[SADDR_W-1:0];
        turn_start = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                pt_we = s_valid && (count_reg < CNT_W'(MAX_POINTS));
            end
            ST_SORT_RD: begin
                pt_raddr = i_reg[IDX_W-1:0];
            end
            ST_SORT_KEY: begin
                pt_raddr = im1[IDX_W-1:0];
            end
            ST_SORT_SHIFT: begin
                pt_raddr = jm2[IDX_W-1:0];
                pt_we    = 1'b1;
                pt_waddr = j_reg[IDX_W-1:0];
                pt_wdata = key_less ? pt_rdata : key_reg;
            end
            ST_SORT_PLACE: begin
                pt_we    = 1'b1;
                pt_waddr = '0;
                pt_wdata = key_reg;
            end
            ST_H_CHECK: begin
                turn_start = can_pop;
                st_we      = !can_pop && (top_reg < TOP_W'(SDEPTH));
            end
            ST_H_TURN: begin
                st_raddr = topm3[SADDR_W-1:0];
                st_we    = turn_res.valid && !turn_res.non_left &&
                           (top_reg < TOP_W'(SDEPTH));
            end
            default: begin
            end
        endcase
    end

    chb_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    chb_ram #(.WIDTH(PW), .DEPTH(SDEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (p_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    chb_turn #(.COORD_BITS(COORD_BITS)) u_turn (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (turn_start),
        .a_x     (a_reg[PW-1:COORD_BITS]),
        .a_y     (a_reg[COORD_BITS-1:0]),
        .b_x     (b_reg[PW-1:COORD_BITS]),
        .b_y     (b_reg[COORD_BITS-1:0]),
        .c_x     (p_reg[PW-1:COORD_BITS]),
        .c_y     (p_reg[COORD_BITS-1:0]),
        .res     (turn_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            top_reg     <= '0;
            ovf_reg     <= 1'b0;
            upper_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg) inside
                ST_LOAD: begin
                    if (s_valid) begin
                        if (count_reg < CNT_W'(MAX_POINTS)) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_last_point) begin
                            i_reg     <= CNT_W'(1);
                            idx_reg   <= '0;
                            upper_reg <= 1'b0;
                            floor_reg <= '0;
                            top_reg   <= '0;
                            // A set that still has one point needs no sort.
                            if (count_reg == '0) begin
                                state_reg <= ST_H_RDP;
                            end else begin
                                state_reg <= ST_SORT_RD;
                            end
                        end
                    end
                end
                ST_SORT_RD: begin
                    state_reg <= ST_SORT_KEY;
                end
                ST_SORT_KEY: begin
                    key_reg   <= pt_rdata;
                    j_reg     <= i_reg;
                    state_reg <= ST_SORT_SHIFT;
                end
                ST_SORT_SHIFT, ST_SORT_PLACE: begin
                    if (state_reg == ST_SORT_SHIFT && key_less) begin
                        j_reg <= jm1;
                        if (j_reg == CNT_W'(1)) begin
                            state_reg <= ST_SORT_PLACE;
                        end
                    end else if (i_reg + CNT_W'(1) == count_reg) begin
                        state_reg <= ST_H_RDP;
                    end else begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= ST_SORT_RD;
                    end
                end
                ST_H_RDP: begin
                    state_reg <= ST_H_GETP;
                end
                ST_H_GETP: begin
                    p_reg     <= pt_rdata;
                    state_reg <= ST_H_CHECK;
                end
                ST_H_CHECK, ST_H_TURN: begin
                    if (state_reg == ST_H_CHECK && can_pop) begin
                        state_reg <= ST_H_TURN;
                    end else if (state_reg == ST_H_TURN && !turn_res.valid) begin
                        state_reg <= ST_H_TURN;
                    end else if (state_reg == ST_H_TURN && turn_res.non_left) begin
                        // Pop: the cached second entry becomes the top.
                        top_reg <= top_reg - TOP_W'(1);
                        b_reg   <= a_reg;
                        if (top_reg >= TOP_W'(3)) begin
                            state_reg <= ST_H_FETCH;
                        end else begin
                            state_reg <= ST_H_CHECK;
                        end
                    end else begin
                        // Push the current point and move to the next one.
                        top_reg <= push_top;
                        a_reg   <= b_reg;
                        b_reg   <= p_reg;
                        k_reg   <= '0;
                        if (!upper_reg) begin
                            if (idx_reg == count_reg - CNT_W'(1)) begin
                                floor_reg <= push_top;
                                upper_reg <= 1'b1;
                                if (count_reg >= CNT_W'(2)) begin
                                    idx_reg   <= count_reg - CNT_W'(2);
                                    state_reg <= ST_H_RDP;
                                end else begin
                                    state_reg <= ST_E_RD;
                                end
                            end else begin
                                idx_reg   <= idx_reg + CNT_W'(1);
                                state_reg <= ST_H_RDP;
                            end
                        end else if (idx_reg == '0) begin
                            state_reg <= ST_E_RD;
                        end else begin
                            idx_reg   <= idx_reg - CNT_W'(1);
                            state_reg <= ST_H_RDP;
                        end
                    end
                end
                ST_H_FETCH: begin
                    a_reg     <= st_rdata;
                    state_reg <= ST_H_CHECK;
                end
                ST_E_RD: begin
                    if (top_reg <= TOP_W'(1)) begin
                        state_reg <= ST_E_NOHULL;
                    end else begin
                        state_reg <= ST_E_OUT;
                    end
                end
                ST_E_OUT: begin
                    if (out_free) begin
                        m_x_reg       <= st_rdata[PW-1:COORD_BITS];
                        m_y_reg       <= st_rdata[COORD_BITS-1:0];
                        m_no_hull_reg <= 1'b0;
                        m_ovf_reg     <= ovf_reg;
                        // The closing copy of the first vertex is not sent.
                        if (k_reg + TOP_W'(2) == top_reg) begin
                            m_last_reg <= 1'b1;
                            count_reg  <= '0;
                            top_reg    <= '0;
                            ovf_reg    <= 1'b0;
                            state_reg  <= ST_LOAD;
                        end else begin
                            m_last_reg <= 1'b0;
                            k_reg      <= k_reg + TOP_W'(1);
                            state_reg  <= ST_E_RD;
                        end
                    end
                end
                ST_E_NOHULL: begin
                    if (out_free) begin
                        m_x_reg       <= '0;
                        m_y_reg       <= '0;
                        m_last_reg    <= 1'b1;
                        m_no_hull_reg <= 1'b1;
                        m_ovf_reg     <= ovf_reg;
                        count_reg     <= '0;
                        top_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hull_x      = m_x_reg;
    assign m_hull_y      = m_y_reg;
    assign m_last_vertex = m_last_reg;
    assign m_no_hull     = m_no_hull_reg;
    assign m_overflowed  = m_ovf_reg;

`ifndef NO_ASSERTIONS
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_W'(SDEPTH))
        else $error("hull stack depth beyond capacity");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_no_hull_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_no_hull_reg |-> m_last_reg)
        else $error("empty hull request not marked as last");

    a_turn_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        turn_res.valid |-> state_reg == ST_H_TURN)
        else $error("turn result arrived outside the turn wait");

    a_sort_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        turn_start |=> state_reg == ST_H_TURN)
        else $error("turn request did not enter the turn wait");
`endif

endmodule

FILE: bench/hull_checker.sv
`timescale 1ns / 100ps
// Checker that watches both channels, predicts the hull of each point set and compares.
module hull_checker #(
    parameter int MAX_POINTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic               s_last_point,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_hull_x,
    input  logic signed [15:0] m_hull_y,
    input  logic               m_last_vertex,
    input  logic               m_no_hull,
    input  logic               m_overflowed,
    output int                 fail_count,
    output int                 pending
);
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last_vertex;
        logic               no_hull;
        logic               overflowed;
    } vertex_t;

    logic signed [15:0] pts_x[MAX_POINTS];
    logic signed [15:0] pts_y[MAX_POINTS];
    logic signed [15:0] stk_x[MAX_POINTS+1];
    logic signed [15:0] stk_y[MAX_POINTS+1];
    int      npts;
    int      depth;
    bit      dropped;
    vertex_t vertex_q[$];

    assign pending = vertex_q.size();

    function automatic longint turn_cross(int a, int b, logic signed [15:0] px,
                                          logic signed [15:0] py);
        longint ux, uy, vx, vy;
        ux = longint'(stk_x[b]) - stk_x[a];
        uy = longint'(stk_y[b]) - stk_y[a];
        vx = longint'(px) - stk_x[a];
        vy = longint'(py) - stk_y[a];
        return ux * vy - uy * vx;
    endfunction

    function automatic void push_point(logic signed [15:0] px, logic signed [15:0] py,
                                       int floor_k);
        while (depth >= 2 && depth > floor_k &&
               turn_cross(depth - 2, depth - 1, px, py) <= 0)
            depth--;
        if (depth < MAX_POINTS + 1) begin
            stk_x[depth] = px;
            stk_y[depth] = py;
            depth++;
        end
    endfunction

    // Sort the stored set, build both chains and queue the vertices.
    function automatic void predict_hull();
        logic signed [15:0] kx, ky;
        int j, t, cnt;
        vertex_t v;
        for (int i = 1; i < npts; i++) begin
            kx = pts_x[i];
            ky = pts_y[i];
            j = i;
            while (j > 0 && (kx < pts_x[j-1] || (kx == pts_x[j-1] && ky < pts_y[j-1]))) begin
                pts_x[j] = pts_x[j-1];
                pts_y[j] = pts_y[j-1];
                j--;
            end
            pts_x[j] = kx;
            pts_y[j] = ky;
        end
        depth = 0;
        for (int i = 0; i < npts; i++) push_point(pts_x[i], pts_y[i], 0);
        t = depth;
        for (int i = npts - 2; i >= 0; i--) push_point(pts_x[i], pts_y[i], t);
        cnt = depth > 0 ? depth - 1 : 0;
        if (cnt == 0) begin
            v = '{x: 0, y: 0, last_vertex: 1, no_hull: 1, overflowed: dropped};
            vertex_q.insert(vertex_q.size(), v);
        end else begin
            for (int k = 0; k < cnt; k++) begin
                v = '{x: stk_x[k], y: stk_y[k], last_vertex: k + 1 == cnt,
                      no_hull: 0, overflowed: dropped};
                vertex_q.insert(vertex_q.size(), v);
            end
        end
        npts = 0;
        dropped = 0;
    endfunction

    always @(posedge aclk) begin
        vertex_t exp_v;
        if (!aresetn) begin
            npts <= 0;
            dropped <= 0;
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (npts < MAX_POINTS) begin
                    pts_x[npts] = s_point_x;
                    pts_y[npts] = s_point_y;
                    npts = npts + 1;
                end else begin
                    dropped = 1;
                end
                if (s_last_point) predict_hull();
            end
            if (m_valid && m_ready) begin
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected vertex (%0d,%0d)", $time, m_hull_x, m_hull_y);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_v = vertex_q.pop_front();
                    if (m_last_vertex !== exp_v.last_vertex || m_no_hull !== exp_v.no_hull
                        || m_overflowed !== exp_v.overflowed
                        || (!exp_v.no_hull && (m_hull_x !== exp_v.x || m_hull_y !== exp_v.y)))
                    begin
                        $display({"%0t: expected x=%0d y=%0d last=%0b none=%0b ovf=%0b,",
                                  " got x=%0d y=%0d last=%0b none=%0b ovf=%0b"},
                                 $time, exp_v.x, exp_v.y, exp_v.last_vertex, exp_v.no_hull,
                                 exp_v.overflowed, m_hull_x, m_hull_y, m_last_vertex,
                                 m_no_hull, m_overflowed);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the convex hull builder testbench: stimulus, receiver stalls and verdict.
module tb;
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_point_x;
    logic signed [15:0] s_point_y;
    logic               s_last_point;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_hull_x;
    logic signed [15:0] m_hull_y;
    logic               m_last_vertex;
    logic               m_no_hull;
    logic               m_overflowed;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    bit                 hold_off_done;

    localparam int CYCLE_LIMIT = 3000000;

    convex_hull_builder dut (.*);

    hull_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // The cycle counter guards against a hung block.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls in a pattern of its own. Once, early on, it holds
    // off for a long stretch so that the block backs up and stops taking
    // requests while the sender keeps offering them.
    initial begin
        int mode;
        m_ready <= 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        repeat (300) @(posedge aclk);
        repeat (2500) @(posedge aclk);
        hold_off_done = 1;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: m_ready <= 1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // A request is offered; valid is held until the handshake completes.
    // The gap before the next request is drawn by the burst logic.
    int burst_left;

    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic last);
        if (burst_left == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1;
        s_point_x <= px;
        s_point_y <= py;
        s_last_point <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Random set: mostly small sets on a narrow grid so collinear points and
    // duplicates are common, sometimes full-range or oversized sets.
    task automatic send_random_set(input int n, input int span);
        logic signed [15:0] px, py;
        for (int i = 0; i < n; i++) begin
            if (span == 0) begin
                px = 16'($urandom);
                py = 16'($urandom);
            end else begin
                px = 16'($signed($urandom_range(0, 2 * span)) - span);
                py = 16'($signed($urandom_range(0, 2 * span)) - span);
            end
            send_point(px, py, i == n - 1);
        end
    endtask

    initial begin
        int sent;
        int n;
        int span;
        aresetn <= 0;
        s_valid <= 0;
        s_point_x <= 0;
        s_point_y <= 0;
        s_last_point <= 0;
        cycle_count = 0;
        burst_left = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed sets: a lone point, two points, all points equal, the
        // coordinate extremes as a square, collinear points on a line.
        send_point(16'sd5, -16'sd7, 1);
        send_point(16'sd32767, -16'sd32768, 0);
        send_point(-16'sd32768, 16'sd32767, 1);
        send_point(16'sd3, 16'sd3, 0);
        send_point(16'sd3, 16'sd3, 0);
        send_point(16'sd3, 16'sd3, 1);
        send_point(16'sd32767, 16'sd32767, 0);
        send_point(-16'sd32768, -16'sd32768, 0);
        send_point(16'sd32767, -16'sd32768, 0);
        send_point(-16'sd32768, 16'sd32767, 0);
        send_point(16'sd0, 16'sd0, 1);
        send_point(16'sd0, 16'sd0, 0);
        send_point(16'sd1, 16'sd1, 0);
        send_point(16'sd2, 16'sd2, 0);
        send_point(-16'sd1, -16'sd1, 1);
        sent = 15;

        // Random sets, with a few that overflow the store; the closing
        // point of an overflowing set is itself dropped.
        while (sent < 430) begin
            case ($urandom_range(0, 19))
                0: n = 70;
                1: n = 64;
                default: n = $urandom_range(1, 12);
            endcase
            span = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            send_random_set(n, span);
            sent += n;
        end
        s_valid <= 0;

        wait (hold_off_done);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
sv/chb_pkg.sv
sv/chb_ram.sv
sv/chb_turn.sv
sv/convex_hull_builder.sv
bench/hull_checker.sv
bench/tb.sv
